/* src/timestamp_smoother_drift_resync_core_macros.svh */
// Assertion macros for the timestamp smoother block.
`ifndef TIMESTAMP_SMOOTHER_DRIFT_RESYNC_CORE_MACROS_SVH
`define TIMESTAMP_SMOOTHER_DRIFT_RESYNC_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSDR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TSDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TSDR_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/tsdr_pkg.sv */
// Shared types and constants of the timestamp smoother block.
`timescale 1ns / 1ps
`default_nettype none
package tsdr_pkg;

    localparam int CMD_W       = 2;
    localparam int KIND_W      = 2;
    localparam int IN_TIME_W   = 48;
    localparam int OUT_TIME_W  = 48;
    localparam int DUR_W       = 32;
    localparam int WLEN_W      = 10;
    localparam int MINS_W      = 10;
    localparam int RTHR_W      = 32;
    localparam int JTHR_W      = 47;
    localparam int FDUR_W      = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRIFT = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_SAMPLES      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESYNC_THRESHOLD = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_THRESHOLD   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_USE_FIXED        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FIXED_DURATION   = 3'd5;

    localparam logic [WLEN_W-1:0] WLEN_RST = 10'd300;
    localparam logic [MINS_W-1:0] MINS_RST = 10'd150;
    localparam logic [RTHR_W-1:0] RTHR_RST = 32'd1800;
    localparam logic [JTHR_W-1:0] JTHR_RST = 47'd180000;
    localparam logic [FDUR_W-1:0] FDUR_RST = 32'd3600;

    typedef struct packed {
        logic [OUT_TIME_W-1:0] out_time;
        logic                  is_end_marker;
        logic [KIND_W-1:0]     resync_kind;
    } t_result;

endpackage
`default_nettype wire

/* src/timestamp_smoother_drift_resync_core.sv */
// Timestamp smoother: monotonic timeline with jump reset and drift-window resync.
//
// Usage:
// Requests enter on the s_axis channel (tdata carries the input time and the
// per-item duration, tuser the command and the time-valid flag). Frames and end
// markers leave on the m_axis channel; tlast marks the end marker and tuser
// carries the resync kind. Reset and unused commands produce no output.
// An accepted request passes stage 1 and stage 2: the first checks for a
// first frame or a jump and reads the oldest drift from the ring memory, the
// second updates the drift sum, decides on a drift resync and writes the ring
// and timeline back, and its result goes from the stage 2 registers into the
// output queue. No request is accepted while the previous one is in stage 1,
// set by that read-modify-write of the ring memory and the drift sum.
// Results go to a two-entry output queue; when the receiver stalls, the queue
// fills and s_axis_tready drops until there is room for one more result.
// Reset loads the register defaults and clears the timeline and window at once;
// the ring memory needs no clearing pass since only written entries are read.
// Registers are written over APB at byte address 8*i and should only be written
// while no request is in flight; writes to regs 0 to 5 clear the drift window.
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_smoother_drift_resync_core_macros.svh"
module timestamp_smoother_drift_resync_core #(
    parameter int WINDOW_DEPTH = 512,
    parameter int TIME_BITS    = 48,
    parameter int DRIFT_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // in_time [47:0], item_duration [79:48]
    input  logic [tsdr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command [1:0], in_time_valid [2]
    input  logic [tsdr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_time [47:0]
    output logic [tsdr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // resync_kind [1:0]
    output logic [tsdr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsdr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tsdr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tsdr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import tsdr_pkg::*;

    localparam int HD_W   = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > WLEN_W) ? CNT_W : WLEN_W) + 1;
    localparam int TOT_W  = DRIFT_BITS + CNT_W + 1;
    localparam int PROD_W = RTHR_W + CNT_W;
    localparam int CW     = ((TOT_W > PROD_W) ? TOT_W : PROD_W) + 2;
    localparam int DF_W   = TIME_BITS + 1;
    localparam int JW     = ((DF_W > JTHR_W) ? DF_W : JTHR_W) + 1;

    localparam logic [CMP_W-1:0]  DEPTH_C  = CMP_W'(WINDOW_DEPTH);
    localparam logic [CNT_W:0]    DEPTH_S  = (CNT_W + 1)'(WINDOW_DEPTH);
    localparam logic [HD_W-1:0]   HEAD_TOP = HD_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(WINDOW_DEPTH);
    localparam logic signed [DRIFT_BITS-1:0] DMAX = {1'b0, {(DRIFT_BITS - 1){1'b1}}};
    localparam logic signed [DRIFT_BITS-1:0] DMIN = {1'b1, {(DRIFT_BITS - 1){1'b0}}};

    // Configuration registers.
    logic [WLEN_W-1:0] r_window_length;
    logic [MINS_W-1:0] r_min_samples;
    logic [RTHR_W-1:0] r_resync_thr;
    logic [JTHR_W-1:0] r_jump_thr;
    logic              r_use_fixed;
    logic [FDUR_W-1:0] r_fixed_dur;

    // Timeline and window state.
    logic                          r_started;
    logic signed [TIME_BITS-1:0]   r_next_time;
    logic signed [TIME_BITS-1:0]   r_last_in;
    logic                          r_last_known;
    logic [HD_W-1:0]               r_head;
    logic [CNT_W-1:0]              r_count;
    logic signed [TOT_W-1:0]       r_total;
    logic signed [DRIFT_BITS-1:0]  r_ring [WINDOW_DEPTH];
    logic signed [DRIFT_BITS-1:0]  r_rd_data;

    // Stage 1 registers.
    logic                          r_v1;
    logic [CMD_W-1:0]              r_s1_cmd;
    logic signed [TIME_BITS-1:0]   r_s1_tin;
    logic                          r_s1_tvalid;
    logic [DUR_W-1:0]              r_s1_dur;

    // Stage 2 registers.
    logic                          r_v2;
    logic [CMD_W-1:0]              r_s2_cmd;
    logic signed [TIME_BITS-1:0]   r_s2_tin;
    logic signed [TIME_BITS-1:0]   r_s2_outt;
    logic signed [DRIFT_BITS-1:0]  r_s2_d;
    logic                          r_s2_clr;
    logic                          r_s2_sample;
    logic                          r_s2_full;
    logic [CNT_W-1:0]              r_s2_count_nx;
    logic [HD_W-1:0]               r_s2_head_nx;
    logic [PROD_W-1:0]             r_s2_prod;
    logic                          r_s2_min_ok;
    logic [HD_W-1:0]               r_s2_widx;
    logic [FDUR_W-1:0]             r_s2_delta;
    logic [KIND_W-1:0]             r_s2_kind;

    // Output queue.
    t_result                       r_q [2];
    logic                          r_q_wp;
    logic                          r_q_rp;
    logic [1:0]                    r_q_cnt;

    logic                   in_acc;
    logic                   out_pop;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;

    // Stage 1 logic.
    logic                          c1_frame;
    logic                          c1_reset;
    logic                          c1_first;
    logic signed [DF_W-1:0]        c1_jdiff;
    logic signed [JW-1:0]          c1_jdiff_x;
    logic signed [JW-1:0]          c1_jthr;
    logic                          c1_jump;
    logic signed [DF_W-1:0]        c1_ddiff;
    logic signed [DRIFT_BITS-1:0]  c1_dsat;
    logic signed [DRIFT_BITS-1:0]  c1_d;
    logic signed [TIME_BITS-1:0]   c1_outt;
    logic                          c1_clr;
    logic [CMP_W-1:0]              c1_wl;
    logic                          c1_sample;
    logic [CNT_W-1:0]              c1_count;
    logic [HD_W-1:0]               c1_head;
    logic                          c1_full;
    logic [CNT_W-1:0]              c1_count_nx;
    logic [HD_W-1:0]               c1_head_inc;
    logic [HD_W-1:0]               c1_head_nx;
    logic [CNT_W:0]                c1_sum_idx;
    logic [HD_W-1:0]               c1_widx;
    logic [PROD_W-1:0]             c1_prod;
    logic [FDUR_W-1:0]             c1_delta;

    // Stage 2 logic.
    logic signed [TOT_W-1:0]       c2_base;
    logic signed [TOT_W-1:0]       c2_old;
    logic signed [TOT_W-1:0]       c2_tot;
    logic signed [CW-1:0]          c2_tot_x;
    logic signed [CW-1:0]          c2_prod_x;
    logic                          c2_resync;
    logic signed [TIME_BITS-1:0]   c2_outt;
    logic                          c2_upd;
    logic                          c2_push;
    t_result                       c2_res;

    logic [HD_W-1:0]               n_head;
    logic [CNT_W-1:0]              n_count;
    logic signed [TOT_W-1:0]       n_total;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_pop = m_axis_tvalid && m_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:3];
    assign pready  = 1'b1;

    assign s_axis_tready = !r_v1 && (({1'b0, r_q_cnt} + {2'b00, r_v2}) < 3'd2);

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WLEN_RST;
            r_min_samples   <= MINS_RST;
            r_resync_thr    <= RTHR_RST;
            r_jump_thr      <= JTHR_RST;
            r_use_fixed     <= 1'b1;
            r_fixed_dur     <= FDUR_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WINDOW_LENGTH:    r_window_length <= pwdata[WLEN_W-1:0];
                REG_MIN_SAMPLES:      r_min_samples   <= pwdata[MINS_W-1:0];
                REG_RESYNC_THRESHOLD: r_resync_thr    <= pwdata[RTHR_W-1:0];
                REG_JUMP_THRESHOLD:   r_jump_thr      <= pwdata[JTHR_W-1:0];
                REG_USE_FIXED:        r_use_fixed     <= pwdata[0];
                REG_FIXED_DURATION:   r_fixed_dur     <= pwdata[FDUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WINDOW_LENGTH:    prdata = APB_DATA_W'(r_window_length);
            REG_MIN_SAMPLES:      prdata = APB_DATA_W'(r_min_samples);
            REG_RESYNC_THRESHOLD: prdata = APB_DATA_W'(r_resync_thr);
            REG_JUMP_THRESHOLD:   prdata = APB_DATA_W'(r_jump_thr);
            REG_USE_FIXED:        prdata = APB_DATA_W'(r_use_fixed);
            REG_FIXED_DURATION:   prdata = APB_DATA_W'(r_fixed_dur);
            default:              prdata = '0;
        endcase
    end

    // Stage 1: first frame and jump detection, drift and window bookkeeping.
    assign c1_frame = (r_s1_cmd == CMD_FRAME);
    assign c1_reset = (r_s1_cmd == CMD_RESET);
    assign c1_first = !r_started;

    assign c1_jdiff   = DF_W'(r_s1_tin) - DF_W'(r_last_in);
    assign c1_jdiff_x = JW'(c1_jdiff);
    assign c1_jthr    = $signed(JW'(r_jump_thr));
    assign c1_jump    = c1_frame && !c1_first && r_s1_tvalid && r_last_known &&
                        ((c1_jdiff_x > c1_jthr) || (c1_jdiff_x < -c1_jthr));

    assign c1_ddiff = DF_W'(r_s1_tin) - DF_W'(r_next_time);

    generate
        if (DF_W > DRIFT_BITS) begin : g_sat
            logic c1_fits;
            assign c1_fits = (&c1_ddiff[DF_W-1:DRIFT_BITS-1]) ||
                             !(|c1_ddiff[DF_W-1:DRIFT_BITS-1]);
            assign c1_dsat = c1_fits ? c1_ddiff[DRIFT_BITS-1:0] :
                             (c1_ddiff[DF_W-1] ? DMIN : DMAX);
        end else begin : g_nosat
            assign c1_dsat = DRIFT_BITS'(c1_ddiff);
        end
    endgenerate

    always_comb begin
        if (c1_reset) begin
            c1_outt = '0;
        end else if (c1_first) begin
            c1_outt = r_s1_tvalid ? r_s1_tin : '0;
        end else if (c1_jump) begin
            c1_outt = r_s1_tin;
        end else begin
            c1_outt = r_next_time;
        end
    end

    assign c1_d   = (c1_first || c1_jump) ? '0 : c1_dsat;
    assign c1_clr = c1_reset || (c1_frame && (c1_first || c1_jump));

    assign c1_wl     = (CMP_W'(r_window_length) > DEPTH_C) ? DEPTH_C : CMP_W'(r_window_length);
    assign c1_sample = c1_frame && r_s1_tvalid && (c1_wl != '0);
    assign c1_count  = c1_clr ? '0 : r_count;
    assign c1_head   = c1_clr ? '0 : r_head;
    assign c1_full   = CMP_W'(c1_count) >= c1_wl;

    assign c1_head_inc = (c1_head == HEAD_TOP) ? '0 : c1_head + 1'b1;
    assign c1_count_nx = (c1_sample && !c1_full) ? c1_count + 1'b1 : c1_count;
    assign c1_head_nx  = (c1_sample && c1_full) ? c1_head_inc : c1_head;

    assign c1_sum_idx = (CNT_W + 1)'(c1_head) + (CNT_W + 1)'(c1_count);
    always_comb begin
        if (c1_full) begin
            c1_widx = c1_head;
        end else if (c1_sum_idx >= DEPTH_S) begin
            c1_widx = HD_W'(c1_sum_idx - DEPTH_S);
        end else begin
            c1_widx = HD_W'(c1_sum_idx);
        end
    end

    assign c1_prod  = PROD_W'(r_resync_thr) * PROD_W'(c1_count_nx);
    assign c1_delta = c1_reset ? '0 :
                      (r_use_fixed ? r_fixed_dur : (r_s1_dur[DUR_W-1] ? '0 : r_s1_dur));

    // Stage 2: drift sum update and resync decision.
    assign c2_base   = r_s2_clr ? '0 : r_total;
    assign c2_old    = r_s2_full ? TOT_W'(r_rd_data) : '0;
    assign c2_tot    = r_s2_sample ? (c2_base + TOT_W'(r_s2_d) - c2_old) : c2_base;
    assign c2_tot_x  = CW'(c2_tot);
    assign c2_prod_x = $signed(CW'(r_s2_prod));
    assign c2_resync = r_s2_sample && r_s2_min_ok &&
                       ((c2_tot_x > c2_prod_x) || (c2_tot_x < -c2_prod_x));
    assign c2_outt   = c2_resync ? r_s2_tin : r_s2_outt;
    assign c2_upd    = r_v2 && ((r_s2_cmd == CMD_FRAME) || (r_s2_cmd == CMD_RESET));
    assign c2_push   = r_v2 && ((r_s2_cmd == CMD_FRAME) || (r_s2_cmd == CMD_END));

    always_comb begin
        c2_res = '0;
        if (r_s2_cmd == CMD_END) begin
            c2_res.is_end_marker = 1'b1;
        end else begin
            c2_res.out_time    = OUT_TIME_W'($unsigned(c2_outt));
            c2_res.resync_kind = c2_resync ? KIND_DRIFT : r_s2_kind;
        end
    end

    always_comb begin
        if (c2_resync) begin
            n_head  = '0;
            n_count = '0;
            n_total = '0;
        end else begin
            n_head  = r_s2_head_nx;
            n_count = r_s2_count_nx;
            n_total = c2_tot;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
            r_v2 <= r_v1;
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd    <= s_axis_tuser[CMD_W-1:0];
            r_s1_tin    <= TIME_BITS'($signed(s_axis_tdata[IN_TIME_W-1:0]));
            r_s1_tvalid <= s_axis_tuser[CMD_W];
            r_s1_dur    <= s_axis_tdata[IN_TIME_W+DUR_W-1:IN_TIME_W];
        end
        if (r_v1) begin
            r_s2_cmd      <= r_s1_cmd;
            r_s2_tin      <= r_s1_tin;
            r_s2_outt     <= c1_outt;
            r_s2_d        <= c1_d;
            r_s2_clr      <= c1_clr;
            r_s2_sample   <= c1_sample;
            r_s2_full     <= c1_full;
            r_s2_count_nx <= c1_count_nx;
            r_s2_head_nx  <= c1_head_nx;
            r_s2_prod     <= c1_prod;
            r_s2_min_ok   <= CMP_W'(c1_count_nx) >= CMP_W'(r_min_samples);
            r_s2_widx     <= c1_widx;
            r_s2_delta    <= c1_delta;
            r_s2_kind     <= c1_jump ? KIND_JUMP : KIND_NONE;
        end
    end

    // Ring memory: read of the oldest drift in stage 1, write of the new drift in stage 2.
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_rd_data <= r_ring[c1_head];
        end
        if (r_v2 && r_s2_sample) begin
            r_ring[r_s2_widx] <= r_s2_d;
        end
    end

    // Input-side timeline state, updated in stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_last_in    <= '0;
            r_last_known <= 1'b0;
        end else if (r_v1 && c1_reset) begin
            r_started    <= 1'b0;
            r_last_in    <= '0;
            r_last_known <= 1'b0;
        end else if (r_v1 && c1_frame) begin
            r_started <= 1'b1;
            if (r_s1_tvalid) begin
                r_last_in    <= r_s1_tin;
                r_last_known <= 1'b1;
            end
        end
    end

    // Output timeline and drift window, written back in stage 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_time <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_total     <= '0;
        end else if (cfg_wr && (cfg_idx <= REG_FIXED_DURATION)) begin
            r_head  <= '0;
            r_count <= '0;
            r_total <= '0;
        end else if (c2_upd) begin
            r_next_time <= c2_outt + TIME_BITS'(r_s2_delta);
            r_head      <= n_head;
            r_count     <= n_count;
            r_total     <= n_total;
        end
    end

    // Output queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= '0;
        end else begin
            if (c2_push) begin
                r_q_wp <= !r_q_wp;
            end
            if (out_pop) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, c2_push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c2_push) begin
            r_q[r_q_wp] <= c2_res;
        end
    end

    assign m_axis_tvalid = (r_q_cnt != '0);
    assign m_axis_tdata  = r_q[r_q_rp].out_time;
    assign m_axis_tlast  = r_q[r_q_rp].is_end_marker;
    assign m_axis_tuser  = r_q[r_q_rp].resync_kind;

    `TSDR_ASSERT(a_stage_excl, i_clk, i_rst_n, !(r_v1 && r_v2), "Two requests in flight at once.")
    `TSDR_ASSERT(a_queue_room, i_clk, i_rst_n, !r_v2 || (r_q_cnt <= 2'd1), "No queue room for result.")
    `TSDR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX, "Window count beyond depth.")
    `TSDR_ASSERT_NEXT(a_issue_gap, i_clk, i_rst_n, in_acc, !s_axis_tready, "Request taken too soon.")
    `TSDR_ASSERT_NEXT(a_drift_clear, i_clk, i_rst_n, c2_upd && c2_resync, r_count == '0, "Window not cleared.")

endmodule
`default_nettype wire

/* sim/tb_timestamp_smoother_drift_resync_core.sv */
// Self-checking testbench of the timestamp smoother with jump reset and drift resync.
`timescale 1ns / 1ps
module tb_timestamp_smoother_drift_resync_core;
    import tsdr_pkg::*;

    localparam int RING_DEPTH = 512;
    localparam longint DRIFT_MAX = 64'sd2147483647;
    localparam logic [47:0] SIGN_FLIP = 48'h8000_0000_0000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 150;

    class timeline_tracker;
        logic [WLEN_W-1:0] window_len;
        logic [MINS_W-1:0] min_fill;
        logic [RTHR_W-1:0] resync_thr;
        logic [JTHR_W-1:0] jump_thr;
        logic              use_fixed;
        logic [FDUR_W-1:0] fixed_dur;
        bit                started;
        logic [47:0]       next_out;
        logic [47:0]       prev_in;
        bit                prev_in_known;
        longint            drift_ring [RING_DEPTH];
        int unsigned       ring_head;
        int unsigned       ring_fill;
        longint            drift_sum;
        t_result           pending_results [$];
        int                mismatches;

        function new();
            window_len = WLEN_RST;
            min_fill   = MINS_RST;
            resync_thr = RTHR_RST;
            jump_thr   = JTHR_RST;
            use_fixed  = 1'b1;
            fixed_dur  = FDUR_RST;
            mismatches = 0;
            restart_timeline();
        endfunction

        function void clear_window();
            ring_head = 0;
            ring_fill = 0;
            drift_sum = 0;
        endfunction

        function void restart_timeline();
            started       = 1'b0;
            next_out      = '0;
            prev_in       = '0;
            prev_in_known = 1'b0;
            clear_window();
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_WINDOW_LENGTH: begin
                    window_len = value[WLEN_W-1:0];
                end
                REG_MIN_SAMPLES: begin
                    min_fill = value[MINS_W-1:0];
                end
                REG_RESYNC_THRESHOLD: begin
                    resync_thr = value[RTHR_W-1:0];
                end
                REG_JUMP_THRESHOLD: begin
                    jump_thr = value[JTHR_W-1:0];
                end
                REG_USE_FIXED: begin
                    use_fixed = value[0];
                end
                REG_FIXED_DURATION: begin
                    fixed_dur = value[FDUR_W-1:0];
                end
                default: begin
                    return;
                end
            endcase
            clear_window();
        endfunction

        // The difference a - b of two signed times, as magnitude plus a flag for b > a.
        function logic [47:0] time_gap(logic [47:0] a, logic [47:0] b, output bit behind);
            logic [47:0] ab;
            logic [47:0] bb;
            ab = a ^ SIGN_FLIP;
            bb = b ^ SIGN_FLIP;
            behind = (ab < bb);
            return behind ? bb - ab : ab - bb;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [47:0] tin, logic tv,
                                   logic [DUR_W-1:0] dur);
            t_result           res;
            logic [47:0]       out_t;
            logic [47:0]       advance;
            logic [47:0]       gap;
            logic [KIND_W-1:0] kind;
            bit                behind;
            longint            drift;
            int unsigned       span;
            int unsigned       slot;
            longint unsigned   total_mag;
            longint unsigned   bound;
            if (cmd == CMD_END) begin
                res.out_time      = '0;
                res.is_end_marker = 1'b1;
                res.resync_kind   = KIND_NONE;
                pending_results.insert(pending_results.size(), res);
                return;
            end
            if (cmd == CMD_RESET) begin
                restart_timeline();
                return;
            end
            if (cmd != CMD_FRAME) begin
                return;
            end
            kind = KIND_NONE;
            if (!started) begin
                started       = 1'b1;
                next_out      = tv ? tin : '0;
                prev_in       = tv ? tin : '0;
                prev_in_known = tv;
                clear_window();
            end
            if (tv && prev_in_known) begin
                gap = time_gap(tin, prev_in, behind);
                if (gap > {1'b0, jump_thr}) begin
                    next_out = tin;
                    clear_window();
                    kind = KIND_JUMP;
                end
            end
            advance = use_fixed ? 48'(fixed_dur) : (dur[DUR_W-1] ? '0 : 48'(dur));
            out_t = next_out;
            span = (window_len > RING_DEPTH) ? RING_DEPTH : window_len;
            if (tv && span > 0) begin
                gap = time_gap(tin, out_t, behind);
                if (!behind) begin
                    drift = (gap > 48'(DRIFT_MAX)) ? DRIFT_MAX : longint'(gap);
                end else begin
                    drift = (gap > 48'(DRIFT_MAX + 1)) ? -DRIFT_MAX - 1 : -longint'(gap);
                end
                if (ring_fill < span) begin
                    slot = ring_head + ring_fill;
                    if (slot >= RING_DEPTH) begin
                        slot -= RING_DEPTH;
                    end
                    drift_ring[slot] = drift;
                    ring_fill++;
                    drift_sum += drift;
                end else begin
                    drift_sum += drift - drift_ring[ring_head];
                    drift_ring[ring_head] = drift;
                    ring_head++;
                    if (ring_head >= RING_DEPTH) begin
                        ring_head = 0;
                    end
                end
                if (ring_fill >= min_fill) begin
                    total_mag = (drift_sum < 0) ? -drift_sum : drift_sum;
                    bound = longint'(resync_thr) * ring_fill;
                    if (total_mag > bound) begin
                        out_t = tin;
                        clear_window();
                        kind = KIND_DRIFT;
                    end
                end
            end
            next_out = out_t + advance;
            if (tv) begin
                prev_in       = tin;
                prev_in_known = 1'b1;
            end
            res.out_time      = out_t;
            res.is_end_marker = 1'b0;
            res.resync_kind   = kind;
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast,
                                   logic [OUT_TUSER_W-1:0] tuser);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_time %h is_end_marker %b resync_kind %0d",
                       tdata, tlast, tuser);
                mismatches++;
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            if (tdata !== want.out_time) begin
                $error("out_time: expected %h, got %h", want.out_time, tdata);
                mismatches++;
            end
            if (tlast !== want.is_end_marker) begin
                $error("is_end_marker: expected %b, got %b", want.is_end_marker, tlast);
                mismatches++;
            end
            if (tuser !== want.resync_kind) begin
                $error("resync_kind: expected %0d, got %0d", want.resync_kind, tuser);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // in_time [47:0], item_duration [79:48]
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // command [1:0], in_time_valid [2]
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // out_time [47:0]
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    // resync_kind [1:0]
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    timeline_tracker tracker;
    int tx_gap_max = 9;
    int rx_gap_max = 9;
    int stall_left = 0;

    timestamp_smoother_drift_resync_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            stall_left = $urandom_range(0, rx_gap_max);
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Returns right after the accepting edge, so a following request can keep tvalid high.
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [47:0] tin, logic tv,
                                logic [DUR_W-1:0] dur);
        int unsigned idle;
        idle = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dur, tin};
        s_axis_tuser  <= {tv, cmd};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        tracker.note_request(cmd, tin, tv, dur);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(logic [WLEN_W-1:0] wl, logic [MINS_W-1:0] ms,
                             logic [RTHR_W-1:0] rthr, logic [JTHR_W-1:0] jthr,
                             logic fixed, logic [FDUR_W-1:0] fdur);
        apb_write(REG_WINDOW_LENGTH, 64'(wl));
        apb_write(REG_MIN_SAMPLES, 64'(ms));
        apb_write(REG_RESYNC_THRESHOLD, 64'(rthr));
        apb_write(REG_JUMP_THRESHOLD, 64'(jthr));
        apb_write(REG_USE_FIXED, 64'(fixed));
        apb_write(REG_FIXED_DURATION, 64'(fdur));
    endtask

    task automatic random_config();
        logic [WLEN_W-1:0] wl;
        logic [JTHR_W-1:0] jthr;
        logic [FDUR_W-1:0] fdur;
        if ($urandom_range(0, 3) == 0) begin
            wl = WLEN_W'($urandom_range(0, 1023));
        end else begin
            wl = WLEN_W'($urandom_range(1, 40));
        end
        if ($urandom_range(0, 3) == 0) begin
            jthr = JTHR_W'({$urandom, $urandom});
        end else begin
            jthr = JTHR_W'($urandom_range(5000, 400000));
        end
        if ($urandom_range(0, 3) == 0) begin
            fdur = $urandom;
        end else begin
            fdur = $urandom_range(0, 8000);
        end
        configure(wl, MINS_W'($urandom_range(0, wl)), $urandom_range(0, 2000), jthr,
                  1'($urandom_range(0, 1)), fdur);
    endtask

    // Mostly frames that follow a source clock running slightly fast or slow, with jitter,
    // so that the drift window fills and resyncs; the rest are jumps, invalid times,
    // negative durations, end markers, resets, unused commands and pauses that drain the results.
    task automatic run_random(int count);
        logic [47:0]      src;
        logic [47:0]      advance;
        logic [DUR_W-1:0] dur;
        int               skew;
        int               jitter;
        int unsigned      pick;
        int               sent;
        bit               counted;
        skew = int'($urandom_range(0, 100)) - 50;
        src = tracker.next_out;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            dur = $urandom_range(0, 4000);
            advance = tracker.use_fixed ? 48'(tracker.fixed_dur) : 48'(dur);
            if (tracker.use_fixed) begin
                dur = $urandom;
            end
            jitter = int'($urandom_range(0, 400)) - 200;
            counted = 1'b1;
            if (pick < 78) begin
                src = src + advance + 48'(skew);
                send_request(CMD_FRAME, src + 48'(jitter), 1'b1, dur);
            end else if (pick < 84) begin
                src = src + advance + 48'(skew);
                send_request(CMD_FRAME, 48'({$urandom, $urandom}), 1'b0, dur);
            end else if (pick < 88) begin
                src = 48'({$urandom, $urandom});
                send_request(CMD_FRAME, src, 1'b1, dur);
            end else if (pick < 91) begin
                src = src + (tracker.use_fixed ? advance : 48'd0) + 48'(skew);
                send_request(CMD_FRAME, src + 48'(jitter), 1'b1, 32'h8000_0000 | $urandom);
            end else if (pick < 94) begin
                send_request(CMD_END, 48'({$urandom, $urandom}), 1'($urandom), $urandom);
            end else if (pick < 96) begin
                send_request(CMD_RESET, 48'({$urandom, $urandom}), 1'($urandom), $urandom);
            end else if (pick < 98) begin
                send_request(CMD_UNUSED, 48'({$urandom, $urandom}), 1'($urandom), $urandom);
                counted = 1'b0;
            end else begin
                drain_results();
                counted = 1'b0;
            end
            if (counted) begin
                sent++;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(CMD_FRAME, 48'h7FFF_FFFF_FFFF, 1'b0, 32'h8000_0000);
        send_request(CMD_FRAME, 48'd1000, 1'b1, 32'h7FFF_FFFF);
        send_request(CMD_FRAME, 48'd4600, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_END, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED, 48'h5555_AAAA_5555, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h8000_0000_0000, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h7FFF_FFFF_FFFF, 1'b1, 32'd0);
        send_request(CMD_RESET, 48'd0, 1'b0, 32'd0);
        // The input crosses the top of the signed range, which reads as a jump.
        send_request(CMD_FRAME, 48'h7FFF_FFFF_F800, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h8000_0000_0610, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h8000_0000_1420, 1'b1, 32'd0);
        // One tick above the jump threshold, then exactly on it.
        send_request(CMD_FRAME, 48'h8000_0002_D341, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h8000_0005_9261, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'h0000_1234_5678, 1'b0, 32'd0);
        send_request(CMD_RESET, 48'hFFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_END, 48'd0, 1'b0, 32'd0);
        send_request(CMD_FRAME, 48'hFFFF_FFFF_FFFF, 1'b1, 32'd0);
        send_request(CMD_FRAME, 48'd3599, 1'b1, 32'd0);
        run_random(PHASE_ITEMS);

        for (int phase = 1; phase < 12; phase++) begin
            drain_results();
            tx_gap_max = (phase % 3 == 0) ? 0 : 9;
            rx_gap_max = (phase % 2 == 0) ? 0 : 9;
            case (phase)
                1: begin
                    configure(10'd8, 10'd4, 32'd100, 47'd50000, 1'b1, 32'd3600);
                end
                2: begin
                    configure(10'd0, 10'd0, 32'd0, 47'd0, 1'b0, 32'd0);
                end
                3: begin
                    configure(10'd1023, 10'd0, 32'd0, 47'h7FFF_FFFF_FFFF, 1'b1, 32'd0);
                    apb_write(REG_SPARE_LO, '1);
                    apb_write(REG_SPARE_HI, '1);
                end
                4: begin
                    configure(10'd512, 10'd1023, 32'hFFFF_FFFF, 47'h7FFF_FFFF_FFFF, 1'b1,
                              32'hFFFF_FFFF);
                end
                5: begin
                    configure(10'd1, 10'd1, 32'd10, 47'd100000, 1'b0, 32'd1000);
                end
                6: begin
                    configure(WLEN_RST, MINS_RST, RTHR_RST, JTHR_RST, 1'b1, FDUR_RST);
                end
                default: begin
                    random_config();
                end
            endcase
            run_random(PHASE_ITEMS);
        end
        drain_results();

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
